// ----- sv/nth_weekday_of_month_core_macros.svh -----
// ----------------------------------------------------------------------------
// nth_weekday_of_month_core_macros.svh
// Assertion macros shared by the nth-weekday-of-month block.
// ----------------------------------------------------------------------------
`ifndef NTH_WEEKDAY_OF_MONTH_CORE_MACROS_SVH
`define NTH_WEEKDAY_OF_MONTH_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define NWM_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define NWM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/nwom_pkg.sv -----
// ----------------------------------------------------------------------------
// nwom_pkg
// Constants, calendar tables and helper functions for the nth-weekday block.
// ----------------------------------------------------------------------------
package nwom_pkg;

	// Field widths
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int OCC_W   = 3;
	localparam int WDAY_W  = 3;
	localparam int DAY_W   = 5;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Register indexes (word address bits)
	localparam logic [1:0] REG_MONTH   = 2'd0;
	localparam logic [1:0] REG_OCC     = 2'd1;
	localparam logic [1:0] REG_WEEKDAY = 2'd2;

	// Weekday code for Sunday in the register encoding
	localparam logic [WDAY_W-1:0] WDAY_SUNDAY = 3'd7;

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [2:0]         wd7_t;

	// Month length in a common year, zero for month codes that mean nothing
	localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	// Days in a common year before the first of each month
	localparam logic [8:0] DAYS_BEFORE [16] = '{
		9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
	};

	// Remainder by 7 of a 12-bit value: 8 is 1 mod 7, so fold octal digits
	function automatic wd7_t mod7(input logic [11:0] v);
		logic [4:0] s;
		logic [3:0] t;
		s = 5'(v[11:9]) + 5'(v[8:6]) + 5'(v[5:3]) + 5'(v[2:0]);
		t = 4'(s[4:3]) + 4'(s[2:0]);
		return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
	endfunction

endpackage

// ----- sv/nth_weekday_of_month_core.sv -----
// ----------------------------------------------------------------------------
// nth_weekday_of_month_core
// Day of the month of the Nth chosen weekday in a chosen month, per year.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer when              Payload
// input     in         start & !busy at clk edge  year
// result    out        done, one cycle            year_out, month_out, day, found
// config    in         psel&penable&pwrite        paddr, pwdata (prdata on read)
//
// One year enters per cycle; its result appears with done after the five
// register stages (divide, reduce, fold, mod 7, compare). busy stays low:
// the pipeline never stalls since results cannot be held off. Reset clears
// the valid bits and loads month 1, occurrence 1, weekday 1 (Monday).
// ----------------------------------------------------------------------------
`include "nth_weekday_of_month_core_macros.svh"

module nth_weekday_of_month_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nwom_pkg::PADDR_W-1:0]  paddr,
	input  logic [nwom_pkg::PDATA_W-1:0]  pwdata,
	output logic [nwom_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [nwom_pkg::YEAR_W-1:0]   year,
	output logic                          done,
	output logic [nwom_pkg::YEAR_W-1:0]   year_out,
	output logic [nwom_pkg::MONTH_W-1:0]  month_out,
	output logic [nwom_pkg::DAY_W-1:0]    day,
	output logic                          found
);
	import nwom_pkg::*;

	// Configuration registers
	month_t            target_month_q;
	logic [OCC_W-1:0]  occurrence_q;
	logic [WDAY_W-1:0] target_weekday_q;

	// Pipeline registers
	logic       vld_s1, vld_s2, vld_s3, vld_s4;
	year_t      year_s1, year_s2, year_s3, year_s4;
	logic [5:0] q25_s1;
	logic [8:0] ym_s2;
	logic       leap_s2, leap_s3, leap_s4;
	logic [8:0] part_s3;
	wd7_t       c7_s3;
	wd7_t       first_s4;

	// Combinational stage logic
	logic        wr_en;
	logic [15:0] q25_prod;
	logic [9:0]  r25_full;
	logic [8:0]  yc400;
	logic        yc_cent;
	logic [6:0]  ym_mod100;
	logic [9:0]  day_sum;
	logic [8:0]  month_off;
	wd7_t        want;
	wd7_t        diff;
	logic [5:0]  cand;
	logic [DAY_W-1:0] mlen;
	logic        cfg_ok;
	logic        hit;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel & penable & pwrite & pready;

	// Hold configuration, load on a completed write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_month_q   <= MONTH_W'(1);
			occurrence_q     <= OCC_W'(1);
			target_weekday_q <= WDAY_W'(1);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_MONTH:   target_month_q   <= pwdata[MONTH_W-1:0];
				REG_OCC:     occurrence_q     <= pwdata[OCC_W-1:0];
				REG_WEEKDAY: target_weekday_q <= pwdata[WDAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Return register contents on read
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_MONTH:   prdata = PDATA_W'(target_month_q);
			REG_OCC:     prdata = PDATA_W'(occurrence_q);
			REG_WEEKDAY: prdata = PDATA_W'(target_weekday_q);
			default:     prdata = '0;
		endcase
	end

	// Valid bits advance every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done   <= vld_s4;
		end
	end

	// Stage 1: quotient of year/16 by 25 through a reciprocal multiply
	assign q25_prod = 16'(year[13:4]) * 16'd41;

	always_ff @(posedge clk) begin
		year_s1 <= year;
		q25_s1  <= q25_prod[15:10];
	end

	// Stage 2: year mod 400, leap flag, and (year - 1) mod 400
	assign r25_full = year_s1[13:4] - 10'(q25_s1) * 10'd25;
	assign yc400    = {r25_full[4:0], year_s1[3:0]};
	assign yc_cent  = (yc400 == 9'd100) || (yc400 == 9'd200) || (yc400 == 9'd300);

	always_ff @(posedge clk) begin
		year_s2 <= year_s1;
		ym_s2   <= (yc400 == 9'd0) ? 9'd399 : yc400 - 9'd1;
		leap_s2 <= (yc400 == 9'd0) || ((year_s1[1:0] == 2'd0) && !yc_cent);
	end

	// Stage 3: fold the 4-, 100- and 400-year terms of the weekday sum
	always_comb begin
		priority if (ym_s2 >= 9'd300) ym_mod100 = 7'(ym_s2 - 9'd300);
		else if (ym_s2 >= 9'd200)     ym_mod100 = 7'(ym_s2 - 9'd200);
		else if (ym_s2 >= 9'd100)     ym_mod100 = 7'(ym_s2 - 9'd100);
		else                          ym_mod100 = ym_s2[6:0];
	end

	always_ff @(posedge clk) begin
		year_s3 <= year_s2;
		leap_s3 <= leap_s2;
		part_s3 <= 9'd1 + 9'(ym_s2[1:0]) * 9'd5 + {ym_mod100, 2'b00};
		c7_s3   <= mod7(12'(ym_s2));
	end

	// Stage 4: weekday of the first of the target month
	assign month_off = DAYS_BEFORE[target_month_q]
		+ 9'((leap_s3 && (target_month_q > MONTH_W'(2))) ? 1 : 0);
	assign day_sum = 10'(part_s3) + 10'(c7_s3) * 10'd6 + 10'(month_off);

	always_ff @(posedge clk) begin
		year_s4  <= year_s3;
		leap_s4  <= leap_s3;
		first_s4 <= mod7(12'(day_sum));
	end

	// Stage 5: locate the occurrence and check it against the month length
	assign want   = (target_weekday_q == WDAY_SUNDAY) ? 3'd0 : target_weekday_q;
	assign diff   = (want >= first_s4) ? 3'(want - first_s4) : 3'(want + 3'd7 - first_s4);
	assign cand   = 6'd1 + 6'(diff) + 6'(occurrence_q - OCC_W'(1)) * 6'd7;
	assign mlen   = (leap_s4 && (target_month_q == MONTH_W'(2))) ? 5'd29
		: MONTH_LEN[target_month_q];
	assign cfg_ok = (target_month_q >= MONTH_W'(1)) && (target_month_q <= MONTH_W'(12))
		&& (occurrence_q >= OCC_W'(1)) && (occurrence_q <= OCC_W'(5))
		&& (target_weekday_q != WDAY_W'(0));
	assign hit    = cfg_ok && (cand <= 6'(mlen));

	always_ff @(posedge clk) begin
		year_out  <= year_s4;
		month_out <= target_month_q;
		day       <= hit ? cand[DAY_W-1:0] : '0;
		found     <= hit;
	end

	// Checks on the pipeline and the result
	`NWM_ASSERT_NEXT(a_pipe_adv, vld_s3, vld_s4, "stage 4 lost a valid item")
	`NWM_ASSERT_NEXT(a_out_adv, vld_s4, done, "result strobe missing after stage 4")
	`NWM_ASSERT_SAME(a_first_rng, vld_s4, first_s4 <= 3'd6, "first weekday out of range")
	`NWM_ASSERT_SAME(a_found_day, done, (found == 1'b1) == (day != 5'd0),
		"found flag disagrees with day")

endmodule
